// File: rtl/core/pgs_pkg.sv
// Package for the packet gap statistics block: command codes, item types and
// saturation helpers. Depends on nothing; used by every other file.
`timescale 1ns / 1ps
package pgs_pkg;

  localparam int MEAN_FRAC_BITS_DEFAULT = 16;
  localparam int MAG_W = 64;
  localparam int CNT_W = 32;

  localparam logic [1:0] CMD_STOP    = 2'd0;
  localparam logic [1:0] CMD_START   = 2'd1;
  localparam logic [1:0] CMD_PACKET  = 2'd2;
  localparam logic [1:0] CMD_INVALID = 2'd3;

  localparam logic [0:0] REG_STREAM_HANDLE = 1'b0;
  localparam logic [0:0] REG_PIN_ID        = 1'b1;

  localparam logic signed [63:0] SMALLEST_RESET = 64'sd2147483647;
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] identifier;
    logic [62:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] handle_tag;
    logic signed [31:0] pin_tag;
    logic [31:0]        first_id;
    logic [31:0]        last_id;
    logic [62:0]        idle_time;
    logic [62:0]        final_time;
    logic [31:0]        gap_count;
    logic signed [63:0] min_gap;
    logic signed [63:0] max_gap;
    logic signed [63:0] mean_gap;
    logic [63:0]        sum_sq_dev;
  } out_item_t;

  // Clamp a 65-bit signed result into 64-bit signed range.
  function automatic logic signed [63:0] sat65(input logic signed [64:0] v);
    logic signed [63:0] r;
    if (v[64] != v[63]) begin
      r = v[64] ? S64_MIN : S64_MAX;
    end else begin
      r = v[63:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic [63:0] r;
    r = v[63] ? (64'd0 - v) : v;
    return r;
  endfunction

endpackage

// File: rtl/core/pgs_chan_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on pgs_pkg for the payload types.
`timescale 1ns / 1ps
interface pgs_in_if;
  logic               valid;
  logic               ready;
  pgs_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pgs_out_if;
  logic               valid;
  logic               ready;
  pgs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/packet_gap_statistics.sv
// Packet gap statistics: a packet in a run occupies the block from its transfer to the next
// possible input transfer, passing in order through preparation, the bit-serial divider, the
// mean update and the bit-serial multiplier. When the two deviations have opposite signs the
// multiplier is skipped. Every other command is handled in the ready state; a record appears in
// the result register in the cycle after the stop or incomplete command that closes the run.
// Synchronous active-high reset returns the block to idle with a cleared record and both tags
// at -1.
// Depends on pgs_pkg, pgs_chan_if, pgs_div and pgs_mul.
`timescale 1ns / 1ps
module packet_gap_statistics #(
  parameter int MEAN_FRAC_BITS = pgs_pkg::MEAN_FRAC_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  pgs_in_if.sink       in_ch,
  pgs_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import pgs_pkg::*;

  localparam logic [2:0] S_READY = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MEAN  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;

  localparam int SH = 2 * MEAN_FRAC_BITS;
  // Largest gap that can be scaled into Q format without overflow.
  localparam logic signed [63:0] LIM = S64_MAX >>> MEAN_FRAC_BITS;

  logic [2:0]         state;
  logic               collecting;
  logic signed [31:0] handle_reg;
  logic signed [31:0] pin_reg;
  logic [62:0]        saved_time;
  logic [62:0]        prev_time;
  logic [31:0]        start_id;
  logic [31:0]        count;
  logic signed [63:0] mean;
  logic [63:0]        m2;
  logic signed [63:0] smin;
  logic signed [63:0] smax;
  logic signed [63:0] gap;
  logic signed [63:0] gsc;
  logic signed [63:0] dlt;
  logic               out_valid;
  out_item_t          out_data;

  in_item_t           item;
  logic               accept;
  logic               emit;
  logic [31:0]        count_inc;
  logic signed [63:0] gap_w;
  logic signed [63:0] g_w;
  logic signed [63:0] d_w;
  logic signed [63:0] d2_w;
  logic signed [63:0] q_w;
  logic               opposite;
  logic               div_start;
  logic               div_done;
  logic [63:0]        div_quo;
  logic               mul_start;
  logic               mul_done;
  logic [127:0]       mul_prod;
  logic [127:0]       prod_sh;
  logic               prod_over;
  logic [63:0]        term;
  logic [64:0]        m2_sum;

  // Input transfers are taken only between packets and when the result
  // register is free or being emptied in the same cycle.
  assign in_ch.ready  = (state == S_READY) && (!out_valid || out_ch.ready);
  assign accept       = in_ch.valid && in_ch.ready;
  assign item         = in_ch.data;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // A stop or incomplete command in a run of at least two gaps emits a record.
  assign emit = accept && collecting && item.cmd != CMD_PACKET &&
                item.cmd != CMD_INVALID && count >= 32'd2;

  assign count_inc = (count == 32'hFFFF_FFFF) ? count : count + 32'd1;
  assign gap_w     = $signed({1'b0, item.timestamp}) - $signed({1'b0, prev_time});

  // Gap scaled to Q format, clamped where the shift would overflow.
  always_comb begin
    if (gap > LIM) begin
      g_w = S64_MAX;
    end else if (gap < -LIM - 64'sd1) begin
      g_w = S64_MIN;
    end else begin
      g_w = gap <<< MEAN_FRAC_BITS;
    end
  end

  assign d_w      = sat65({g_w[63], g_w} - {mean[63], mean});
  assign q_w      = dlt[63] ? (64'sd0 - $signed(div_quo)) : $signed(div_quo);
  assign d2_w     = sat65({gsc[63], gsc} - {mean[63], mean});
  assign opposite = (dlt[63] && !d2_w[63] && d2_w != 64'sd0) ||
                    (!dlt[63] && dlt != 64'sd0 && d2_w[63]);

  assign div_start = (state == S_PREP);
  assign mul_start = (state == S_MEAN) && !opposite;

  // The squared deviation is brought back to whole ns squared and clamped.
  assign prod_sh   = mul_prod >> SH;
  assign prod_over = |(mul_prod >> (64 + SH));
  assign term      = prod_over ? 64'hFFFF_FFFF_FFFF_FFFF : prod_sh[63:0];
  assign m2_sum    = {1'b0, m2} + {1'b0, term};

  pgs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag64(d_w)),
    .divisor  (count),
    .done     (div_done),
    .quotient (div_quo)
  );

  pgs_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mag64(dlt)),
    .b       (mag64(d2_w)),
    .done    (mul_done),
    .product (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_READY;
      collecting <= 1'b0;
      out_valid  <= 1'b0;
      handle_reg <= -32'sd1;
      pin_reg    <= -32'sd1;
      saved_time <= '0;
      prev_time  <= '0;
      start_id   <= '0;
      count      <= '0;
      mean       <= '0;
      m2         <= '0;
      smin       <= SMALLEST_RESET;
      smax       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_STREAM_HANDLE: handle_reg <= cfg_data;
          REG_PIN_ID:        pin_reg    <= cfg_data;
          default:           handle_reg <= handle_reg;
        endcase
      end
      case (state)
        S_READY: begin
          if (accept) begin
            if (!collecting && item.cmd == CMD_START) begin
              start_id   <= item.identifier;
              prev_time  <= saved_time;
              count      <= '0;
              collecting <= 1'b1;
            end else if (!collecting && item.cmd == CMD_PACKET) begin
              saved_time <= item.timestamp;
              count      <= count_inc;
            end else if (collecting && item.cmd == CMD_PACKET) begin
              prev_time <= item.timestamp;
              count     <= count_inc;
              gap       <= gap_w;
              if (gap_w < smin) begin
                smin <= gap_w;
              end
              if (gap_w > smax) begin
                smax <= gap_w;
              end
              state <= S_PREP;
            end else begin
              // Stop, incomplete or invalid command: a stop or incomplete one emits when
              // the run holds at least two gaps; each then clears the record and goes idle.
              if (emit) begin
                out_data.handle_tag <= handle_reg;
                out_data.pin_tag    <= pin_reg;
                out_data.first_id   <= start_id;
                out_data.last_id    <= item.identifier;
                out_data.idle_time  <= saved_time;
                out_data.final_time <= prev_time;
                out_data.gap_count  <= count;
                out_data.min_gap    <= smin;
                out_data.max_gap    <= smax;
                out_data.mean_gap   <= mean;
                out_data.sum_sq_dev <= m2;
              end
              collecting <= 1'b0;
              saved_time <= '0;
              prev_time  <= '0;
              start_id   <= '0;
              count      <= '0;
              mean       <= '0;
              m2         <= '0;
              smin       <= SMALLEST_RESET;
              smax       <= '0;
            end
          end
        end
        S_PREP: begin
          gsc   <= g_w;
          dlt   <= d_w;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            mean  <= sat65({mean[63], mean} + {q_w[63], q_w});
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          state <= opposite ? S_READY : S_MUL;
        end
        S_MUL: begin
          if (mul_done) begin
            m2    <= m2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : m2_sum[63:0];
            state <= S_READY;
          end
        end
        default: state <= S_READY;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_only_between: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == S_READY)
    else $error("input ready outside the ready state");

  a_packet_starts_update: assert property (@(posedge clk) disable iff (rst)
    (accept && collecting && item.cmd == CMD_PACKET) |=> state == S_PREP)
    else $error("packet in a run did not start the update");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |=> (state == S_DIV || state == S_MEAN))
    else $error("division left to an unexpected state");

  a_no_emit_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_READY) |=> !$rose(out_valid))
    else $error("record emitted during a packet update");
`endif

endmodule

// File: rtl/core/pgs_div.sv
// Bit-serial restoring divider: 64-bit magnitude by 32-bit count, one
// quotient bit per cycle. Depends on pgs_pkg.
`timescale 1ns / 1ps
module pgs_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pgs_pkg::MAG_W-1:0]    dividend,
  input  logic [pgs_pkg::CNT_W-1:0]    divisor,
  output logic                         done,
  output logic [pgs_pkg::MAG_W-1:0]    quotient
);
  import pgs_pkg::*;

  logic [MAG_W-1:0] quo;
  logic [CNT_W:0]   rem;
  logic [CNT_W-1:0] dvs;
  logic [5:0]       cnt;
  logic             busy;
  logic [CNT_W:0]   trial;
  logic             fits;

  assign trial    = {rem[CNT_W-1:0], quo[MAG_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= fits ? (trial - {1'b0, dvs}) : trial;
        quo <= {quo[MAG_W-2:0], fits};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: rtl/core/pgs_mul.sv
// Bit-serial shift-add multiplier giving the full 128-bit product of two
// 64-bit magnitudes, one multiplier bit per cycle. Depends on pgs_pkg.
`timescale 1ns / 1ps
module pgs_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pgs_pkg::MAG_W-1:0]     a,
  input  logic [pgs_pkg::MAG_W-1:0]     b,
  output logic                          done,
  output logic [2*pgs_pkg::MAG_W-1:0]   product
);
  import pgs_pkg::*;

  logic [MAG_W-1:0] hi;
  logic [MAG_W-1:0] lo;
  logic [MAG_W-1:0] mcand;
  logic [5:0]       cnt;
  logic             busy;
  logic [MAG_W:0]   sum;

  assign sum     = {1'b0, hi} + {1'b0, (lo[0] ? mcand : {MAG_W{1'b0}})};
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        hi    <= '0;
        lo    <= a;
        mcand <= b;
      end else if (busy) begin
        hi  <= sum[MAG_W:1];
        lo  <= {sum[0], lo[MAG_W-1:1]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: tb/testbench.sv
// Self-checking testbench for packet_gap_statistics: a directed table, then
// random runs of start, packet, stop and invalid commands under varied flow control.
// Depends on pgs_pkg, pgs_chan_if and the block's RTL.
`timescale 1ns / 1ps
module testbench;
  import pgs_pkg::*;

  localparam int FRAC = MEAN_FRAC_BITS_DEFAULT;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [31:0] cfg_data;

  pgs_in_if in_ch ();
  pgs_out_if out_ch ();

  packet_gap_statistics u_top (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // A row of the directed table. When pinned is set, the record that the row
  // causes is the hand-written one below rather than the predicted one.
  typedef struct {
    in_item_t item;
    bit       pinned;
  } table_row_t;

  // Flow-control knobs for the sender and the receiver processes.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_request;
  int unsigned error_count;
  bit          in_pinned;

  // Records that the block still owes us, oldest first.
  out_item_t   pending_records[$];
  out_item_t   pinned_record;

  // Our own copy of the block's configuration and statistics state.
  logic signed [31:0] tag_handle = -32'sd1;
  logic signed [31:0] tag_pin = -32'sd1;
  bit                 in_run;
  logic [62:0]        idle_stamp;
  logic [62:0]        last_stamp;
  logic [31:0]        run_start_id;
  logic [31:0]        gaps_seen;
  logic signed [63:0] avg_gap;
  logic [63:0]        dev_sq_sum;
  logic signed [63:0] least_gap;
  logic signed [63:0] most_gap;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Clamp a 65-bit signed sum into the signed 64-bit range.
  function automatic logic signed [63:0] clamp64(input logic signed [64:0] v);
    if (v > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      return S64_MAX;
    end
    if (v < -65'sh0_8000_0000_0000_0000) begin
      return S64_MIN;
    end
    return v[63:0];
  endfunction

  task automatic clear_stats();
    idle_stamp = '0;
    last_stamp = '0;
    run_start_id = '0;
    gaps_seen = '0;
    avg_gap = '0;
    dev_sq_sum = '0;
    least_gap = SMALLEST_RESET;
    most_gap = '0;
  endtask

  // Fold one gap into the Welford mean and M2 and the extremes.
  task automatic fold_gap(input logic signed [63:0] gap);
    logic signed [63:0] limit;
    logic signed [63:0] scaled;
    logic signed [63:0] dev;
    logic signed [63:0] dev_after;
    logic signed [63:0] step;
    logic [63:0]        dev_mag;
    logic [63:0]        dev_after_mag;
    logic [63:0]        quot;
    logic [127:0]       product;
    logic [63:0]        term;
    logic [64:0]        m2_sum;
    limit = S64_MAX >>> FRAC;
    if (gap > limit) begin
      scaled = S64_MAX;
    end else if (gap < -limit - 64'sd1) begin
      scaled = S64_MIN;
    end else begin
      scaled = gap <<< FRAC;
    end
    dev = clamp64($signed({scaled[63], scaled}) - $signed({avg_gap[63], avg_gap}));
    dev_mag = dev[63] ? 64'd0 - dev : dev;
    quot = dev_mag / {32'd0, gaps_seen};
    if (dev[63]) begin
      step = quot[63] ? S64_MIN : -$signed(quot);
    end else begin
      step = quot;
    end
    avg_gap = clamp64($signed({avg_gap[63], avg_gap}) + $signed({step[63], step}));
    dev_after = clamp64($signed({scaled[63], scaled}) - $signed({avg_gap[63], avg_gap}));
    dev_after_mag = dev_after[63] ? 64'd0 - dev_after : dev_after;
    // Opposite signs of the two deviations contribute nothing to M2.
    if ((dev < 0 && dev_after > 0) || (dev > 0 && dev_after < 0)) begin
      term = '0;
    end else begin
      product = {64'd0, dev_mag} * {64'd0, dev_after_mag};
      product = product >> (2 * FRAC);
      term = (product[127:64] != 0) ? '1 : product[63:0];
    end
    m2_sum = {1'b0, dev_sq_sum} + {1'b0, term};
    dev_sq_sum = m2_sum[64] ? '1 : m2_sum[63:0];
    if (gap < least_gap) begin
      least_gap = gap;
    end
    if (gap > most_gap) begin
      most_gap = gap;
    end
  endtask

  // Advance the statistics copy by one command; report any record it closes.
  task automatic gap_record_step(input in_item_t it, output bit emitted,
                                 output out_item_t rec);
    logic signed [63:0] gap;
    emitted = 1'b0;
    rec = '0;
    if (!in_run) begin
      case (it.cmd)
        CMD_START: begin
          run_start_id = it.identifier;
          last_stamp = idle_stamp;
          gaps_seen = '0;
          in_run = 1'b1;
        end
        CMD_PACKET: begin
          idle_stamp = it.timestamp;
          if (gaps_seen != '1) gaps_seen = gaps_seen + 1;
        end
        default: clear_stats();
      endcase
    end else if (it.cmd == CMD_PACKET) begin
      gap = $signed({1'b0, it.timestamp}) - $signed({1'b0, last_stamp});
      last_stamp = it.timestamp;
      if (gaps_seen != '1) gaps_seen = gaps_seen + 1;
      fold_gap(gap);
    end else begin
      // A stop or an incomplete command closes the run; an invalid one drops it.
      if (it.cmd != CMD_INVALID && gaps_seen >= 2) begin
        emitted = 1'b1;
        rec.handle_tag = tag_handle;
        rec.pin_tag = tag_pin;
        rec.first_id = run_start_id;
        rec.last_id = it.identifier;
        rec.idle_time = idle_stamp;
        rec.final_time = last_stamp;
        rec.gap_count = gaps_seen;
        rec.min_gap = least_gap;
        rec.max_gap = most_gap;
        rec.mean_gap = avg_gap;
        rec.sum_sq_dev = dev_sq_sum;
      end
      in_run = 1'b0;
      clear_stats();
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Everything is sampled on the pre-edge values, so the order of processes
  // within the clock edge does not matter.
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    out_item_t rec;
    bit        emitted;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STREAM_HANDLE: tag_handle = cfg_data;
          REG_PIN_ID:        tag_pin = cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_records.size() == 0) begin
          $error("record transfer with no record expected");
          error_count++;
        end else begin
          want = pending_records.pop_front();
          compare_field("handle_tag", 64'(want.handle_tag), 64'(got.handle_tag));
          compare_field("pin_tag", 64'(want.pin_tag), 64'(got.pin_tag));
          compare_field("first_id", 64'(want.first_id), 64'(got.first_id));
          compare_field("last_id", 64'(want.last_id), 64'(got.last_id));
          compare_field("idle_time", 64'(want.idle_time), 64'(got.idle_time));
          compare_field("final_time", 64'(want.final_time), 64'(got.final_time));
          compare_field("gap_count", 64'(want.gap_count), 64'(got.gap_count));
          compare_field("min_gap", want.min_gap, got.min_gap);
          compare_field("max_gap", want.max_gap, got.max_gap);
          compare_field("mean_gap", want.mean_gap, got.mean_gap);
          compare_field("sum_sq_dev", want.sum_sq_dev, got.sum_sq_dev);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        gap_record_step(in_ch.data, emitted, rec);
        if (emitted) begin
          pending_records.push_back(in_pinned ? pinned_record : rec);
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request so that the
  // block fills up and pushes back on its input.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left = 3000;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one item and wait for its transfer. Valid stays high afterwards so
  // that back-to-back items never lower and raise it in the same step.
  task automatic send_item(input in_item_t it, input bit pinned);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    in_pinned <= pinned;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Let every record drain and any packet update still in progress finish, so
  // the block is idle before the registers change.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    wait (pending_records.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  function automatic in_item_t make_item(input logic [1:0] cmd, input logic [31:0] ident,
                                         input logic [62:0] stamp);
    in_item_t it;
    it.cmd = cmd;
    it.identifier = ident;
    it.timestamp = stamp;
    return it;
  endfunction

  function automatic logic [62:0] any_stamp();
    return 63'({$urandom, $urandom});
  endfunction

  // One random run: mostly an idle/start/packets sequence with random content,
  // closed by a stop or an incomplete command, sometimes noise or a run broken by an invalid code.
  task automatic random_run(inout int unsigned sent);
    logic [62:0] stamp;
    int unsigned packets;
    int unsigned pick;
    logic [1:0] closing;
    if ($urandom_range(99) < 15) begin
      send_item(make_item(2'($urandom_range(3)), $urandom, any_stamp()), 1'b0);
      sent++;
      return;
    end
    stamp = ($urandom_range(3) == 0) ? any_stamp() : 63'($urandom);
    repeat ($urandom_range(2)) begin
      send_item(make_item(CMD_PACKET, $urandom, stamp), 1'b0);
      sent++;
    end
    send_item(make_item(CMD_START, $urandom, any_stamp()), 1'b0);
    sent++;
    packets = ($urandom_range(9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
    repeat (packets) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        stamp = any_stamp();
      end else if (pick == 1) begin
        stamp = stamp - $urandom_range(5000);
      end else if (pick == 2) begin
        stamp = 63'(stamp + {$urandom_range(32'hFFFF), $urandom});
      end else begin
        stamp = stamp + $urandom_range(2000);
      end
      send_item(make_item(CMD_PACKET, $urandom, stamp), 1'b0);
      sent++;
    end
    pick = $urandom_range(19);
    closing = (pick == 0) ? CMD_INVALID : (pick < 10) ? CMD_STOP : CMD_START;
    send_item(make_item(closing, $urandom, any_stamp()), 1'b0);
    sent++;
  endtask

  initial begin
    table_row_t directed[$];
    int unsigned sent;
    int unsigned phase;
    logic [31:0] handles[3];
    logic [31:0] pins[3];

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_STREAM_HANDLE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    in_pinned = 1'b0;
    hold_request = 1'b0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    in_run = 1'b0;
    clear_stats();

    // After reset both tags read -1. Gaps of 10 ns from an idle stamp of 100
    // give a flat mean of 10 in Q47.16 and no spread.
    pinned_record = '{handle_tag: -32'sd1, pin_tag: -32'sd1, first_id: 32'd5,
                      last_id: 32'd9, idle_time: 63'd100, final_time: 63'd130,
                      gap_count: 32'd3, min_gap: 64'sd10, max_gap: 64'sd10,
                      mean_gap: 64'sd655360, sum_sq_dev: 64'd0};

    directed = '{
      '{make_item(CMD_STOP, 32'd0, 63'd0), 1'b0},
      '{make_item(CMD_PACKET, 32'd0, 63'd100), 1'b0},
      '{make_item(CMD_START, 32'd5, 63'd0), 1'b0},
      '{make_item(CMD_PACKET, 32'd0, 63'd110), 1'b0},
      '{make_item(CMD_PACKET, 32'd0, 63'd120), 1'b0},
      '{make_item(CMD_PACKET, 32'd0, 63'd130), 1'b0},
      '{make_item(CMD_STOP, 32'd9, 63'd0), 1'b1},
      // Timestamp extremes: the gaps saturate the scaled value both ways.
      '{make_item(CMD_PACKET, '1, '1), 1'b0},
      '{make_item(CMD_START, '1, '1), 1'b0},
      '{make_item(CMD_PACKET, '1, 63'd0), 1'b0},
      '{make_item(CMD_PACKET, '1, '1), 1'b0},
      '{make_item(CMD_PACKET, 32'd0, 63'd0), 1'b0},
      '{make_item(CMD_START, 32'd0, '1), 1'b0},
      // A run with a single gap closes without a record.
      '{make_item(CMD_START, 32'd7, 63'd0), 1'b0},
      '{make_item(CMD_PACKET, 32'd7, 63'd50), 1'b0},
      '{make_item(CMD_STOP, 32'd7, 63'd0), 1'b0},
      // An invalid code in the middle of a run drops the run silently.
      '{make_item(CMD_START, 32'h8000_0000, 63'd0), 1'b0},
      '{make_item(CMD_PACKET, 32'd0, 63'd1000), 1'b0},
      '{make_item(CMD_PACKET, 32'd0, 63'd900), 1'b0},
      '{make_item(CMD_PACKET, 32'd0, 63'd5000), 1'b0},
      '{make_item(CMD_INVALID, '1, '1), 1'b0},
      '{make_item(CMD_INVALID, 32'd0, 63'd0), 1'b0},
      '{make_item(CMD_START, 32'h1234_5678, 63'd0), 1'b0},
      '{make_item(CMD_PACKET, 32'd0, 63'h2AAA_AAAA_AAAA_AAAA), 1'b0},
      '{make_item(CMD_PACKET, 32'd0, 63'h5555_5555_5555_5555), 1'b0}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_item(directed[i].item, directed[i].pinned);
    end
    // Close the last directed run with an incomplete command.
    send_item(make_item(CMD_START, 32'hFFFF_0000, 63'd0), 1'b0);
    quiesce();

    handles = '{32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    pins = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};
    sent = 0;
    for (phase = 0; phase < 3; phase++) begin
      write_reg(REG_STREAM_HANDLE, handles[phase]);
      write_reg(REG_PIN_ID, pins[phase]);
      case (phase)
        0: begin
          send_idle_pct = 38;
          recv_stall_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_stall_pct = 38;
          hold_request = 1'b1;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      while (sent < (phase + 1) * 530) begin
        random_run(sent);
      end
      quiesce();
    end

    // quiesce has already waited out the block's latency after the last record.
    if (error_count == 0 && pending_records.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pgs_pkg.sv
rtl/core/pgs_chan_if.sv
rtl/core/pgs_div.sv
rtl/core/pgs_mul.sv
rtl/core/packet_gap_statistics.sv
tb/testbench.sv
